// ----- src/mte_pkg.sv -----
package mte_pkg;

    // event codes on the func field
    localparam logic [2:0] FN_KEY     = 3'd0;
    localparam logic [2:0] FN_TICK    = 3'd1;
    localparam logic [2:0] FN_DELETE  = 3'd2;
    localparam logic [2:0] FN_NEWNAME = 3'd3;
    localparam logic [2:0] FN_FINISH  = 3'd4;
    localparam logic [2:0] FN_SETCOL  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_DISP  = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    localparam logic [6:0]  CH_SPACE      = 7'h20;
    localparam logic [6:0]  CH_NUL        = 7'h00;
    localparam logic [31:0] TIMEOUT_RESET = 32'd4000;

    // letters of each digit key, phone layout
    localparam logic [6:0] KEY_LETTERS [10][4] = '{
        '{7'h20, 7'h2E, 7'h00, 7'h00},
        '{7'h00, 7'h00, 7'h00, 7'h00},
        '{7'h41, 7'h42, 7'h43, 7'h00},
        '{7'h44, 7'h45, 7'h46, 7'h00},
        '{7'h47, 7'h48, 7'h49, 7'h00},
        '{7'h4A, 7'h4B, 7'h4C, 7'h00},
        '{7'h4D, 7'h4E, 7'h4F, 7'h00},
        '{7'h50, 7'h51, 7'h52, 7'h53},
        '{7'h54, 7'h55, 7'h56, 7'h00},
        '{7'h57, 7'h58, 7'h59, 7'h5A}
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_en;
        logic ld_char;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic stream_start;
        logic out_free;
        logic idx_last;
    } t_status;

    // number of letters on a key, zero for keys without letters
    function automatic logic [2:0] key_count(input logic [3:0] key);
        logic [2:0] cnt;
        case (key)
            4'd0:    cnt = 3'd2;
            4'd2:    cnt = 3'd3;
            4'd3:    cnt = 3'd3;
            4'd4:    cnt = 3'd3;
            4'd5:    cnt = 3'd3;
            4'd6:    cnt = 3'd3;
            4'd7:    cnt = 3'd4;
            4'd8:    cnt = 3'd3;
            4'd9:    cnt = 3'd4;
            default: cnt = 3'd0;
        endcase
        return cnt;
    endfunction

    function automatic logic [6:0] key_letter(input logic [3:0] key, input logic [1:0] idx);
        logic [6:0] ch;
        if (key > 4'd9) begin
            ch = CH_NUL;
        end else begin
            ch = KEY_LETTERS[key][idx];
        end
        return ch;
    endfunction

endpackage

// ----- src/mte_ctrl.sv -----
module mte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mte_pkg::t_status  i_status,
    output mte_pkg::t_cmd     o_cmd
);

    mte_pkg::t_state r_state;
    mte_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mte_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.ld_char = 1'b0;
        o_stall       = 1'b1;
        case (r_state)
            mte_pkg::ST_IDLE: begin
                o_stall      = !i_status.out_free;
                o_cmd.accept = i_valid && i_status.out_free;
                if (o_cmd.accept && i_status.stream_start) begin
                    n_state = mte_pkg::ST_READ;
                end
            end
            mte_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = mte_pkg::ST_LOAD;
            end
            mte_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.ld_char = 1'b1;
                    n_state = i_status.idx_last ? mte_pkg::ST_IDLE : mte_pkg::ST_READ;
                end
            end
            default: begin
                n_state = mte_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/mte_dp.sv -----
module mte_dp #(
    parameter int NAME_LEN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mte_pkg::t_cmd     i_cmd,
    output mte_pkg::t_status  o_status,
    input  logic [2:0]        i_func,
    input  logic [3:0]        i_key_digit,
    input  logic [4:0]        i_column_in,
    input  logic              i_cfg_valid,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [6:0]        o_char_code,
    output logic [4:0]        o_column,
    output logic              o_last
);

    localparam int CW = $clog2(NAME_LEN + 1);
    localparam int AW = $clog2(NAME_LEN);

    logic [6:0]    r_mem [NAME_LEN];
    logic [6:0]    r_rd_data;

    logic [31:0]   r_timeout;
    logic [CW-1:0] r_cursor, n_cursor;
    logic          r_pend, n_pend;
    logic [3:0]    r_pkey, n_pkey;
    logic [1:0]    r_cyc, n_cyc;
    logic [6:0]    r_shown, n_shown;
    logic          r_timer, n_timer;
    logic [31:0]   r_tick, n_tick;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_last_idx, n_last_idx;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_kind, n_kind;
    logic [6:0]    r_char, n_char;
    logic [4:0]    r_col, n_col;
    logic          r_olast, n_olast;

    logic          commit_ok;
    logic [CW-1:0] cursor_c;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [2:0]    cnt;
    logic          key_new;
    logic [1:0]    cyc_base;
    logic [31:0]   tick_inc;
    logic [31:0]   period;
    logic          expire;

    // a commit lands at the cursor unless the store is full
    assign commit_ok = r_pend && (r_cursor < CW'(NAME_LEN));
    assign cursor_c  = commit_ok ? r_cursor + CW'(1) : r_cursor;
    assign mem_addr  = AW'(r_cursor);

    assign cnt      = mte_pkg::key_count(i_key_digit);
    assign key_new  = !r_pend || (r_pkey != i_key_digit);
    assign tick_inc = r_tick + 32'd1;
    assign period   = (r_timeout == 32'd0) ? 32'd1 : r_timeout;
    assign expire   = !(tick_inc < period);

    assign o_status.stream_start = (i_func == mte_pkg::FN_FINISH) && (cursor_c != CW'(0));
    assign o_status.out_free     = !r_out_valid || !i_stall;
    assign o_status.idx_last     = (r_idx == r_last_idx);

    always_comb begin
        n_cursor    = r_cursor;
        n_pend      = r_pend;
        n_pkey      = r_pkey;
        n_cyc       = r_cyc;
        n_shown     = r_shown;
        n_timer     = r_timer;
        n_tick      = r_tick;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_out_valid = r_out_valid && i_stall;
        n_kind      = r_kind;
        n_char      = r_char;
        n_col       = r_col;
        n_olast     = r_olast;
        mem_we      = 1'b0;
        cyc_base    = key_new ? 2'd0 : r_cyc;
        if (3'(cyc_base) >= cnt) begin
            cyc_base = 2'd0;
        end

        if (i_cmd.accept) begin
            case (i_func)
                mte_pkg::FN_KEY: begin
                    if (cnt != 3'd0) begin
                        if (key_new) begin
                            mem_we   = commit_ok;
                            n_cursor = cursor_c;
                            n_pkey   = i_key_digit;
                            n_pend   = 1'b1;
                        end
                        n_tick      = 32'd0;
                        n_shown     = mte_pkg::key_letter(i_key_digit, cyc_base);
                        n_cyc       = (3'(cyc_base) + 3'd1 == cnt) ? 2'd0 : cyc_base + 2'd1;
                        n_out_valid = 1'b1;
                        n_kind      = mte_pkg::KIND_DISP;
                        n_char      = mte_pkg::key_letter(i_key_digit, cyc_base);
                        n_col       = 5'(key_new ? cursor_c : r_cursor);
                        n_olast     = 1'b1;
                    end
                end
                mte_pkg::FN_TICK: begin
                    if (!expire) begin
                        n_tick = tick_inc;
                    end else begin
                        n_tick = 32'd0;
                        if (r_timer) begin
                            mem_we      = commit_ok;
                            n_cursor    = cursor_c;
                            n_pend      = 1'b0;
                            n_shown     = mte_pkg::CH_SPACE;
                            n_cyc       = 2'd0;
                            n_out_valid = 1'b1;
                            n_kind      = mte_pkg::KIND_DISP;
                            n_char      = mte_pkg::CH_SPACE;
                            n_col       = 5'(cursor_c);
                            n_olast     = 1'b1;
                        end
                    end
                end
                mte_pkg::FN_DELETE: begin
                    if (r_pend) begin
                        n_pend = 1'b0;
                    end else if (r_cursor != CW'(0)) begin
                        n_cursor = r_cursor - CW'(1);
                    end
                    n_cyc       = 2'd0;
                    n_tick      = 32'd0;
                    n_shown     = mte_pkg::CH_SPACE;
                    n_out_valid = 1'b1;
                    n_kind      = mte_pkg::KIND_DISP;
                    n_char      = mte_pkg::CH_SPACE;
                    n_col       = 5'((!r_pend && r_cursor != CW'(0)) ? r_cursor - CW'(1)
                                                                     : r_cursor);
                    n_olast     = 1'b1;
                end
                mte_pkg::FN_NEWNAME: begin
                    n_cursor = CW'(0);
                    n_pend   = 1'b0;
                    n_cyc    = 2'd0;
                    n_shown  = mte_pkg::CH_SPACE;
                    n_timer  = 1'b1;
                end
                mte_pkg::FN_FINISH: begin
                    mem_we     = commit_ok;
                    n_cursor   = cursor_c;
                    n_pend     = 1'b0;
                    n_cyc      = 2'd0;
                    n_timer    = 1'b0;
                    n_idx      = AW'(0);
                    n_last_idx = AW'(cursor_c - CW'(1));
                    if (cursor_c == CW'(0)) begin
                        n_out_valid = 1'b1;
                        n_kind      = mte_pkg::KIND_EMPTY;
                        n_char      = mte_pkg::CH_NUL;
                        n_col       = 5'd0;
                        n_olast     = 1'b1;
                    end
                end
                mte_pkg::FN_SETCOL: begin
                    n_cursor = (32'(i_column_in) > 32'(NAME_LEN)) ? CW'(NAME_LEN)
                                                                  : CW'(i_column_in);
                end
                default: begin
                end
            endcase
        end

        // readout of one stored character
        if (i_cmd.ld_char) begin
            n_out_valid = 1'b1;
            n_kind      = mte_pkg::KIND_NAME;
            n_char      = r_rd_data;
            n_col       = 5'(r_idx);
            n_olast     = o_status.idx_last;
            n_idx       = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= mte_pkg::TIMEOUT_RESET;
            r_cursor    <= '0;
            r_pend      <= 1'b0;
            r_pkey      <= '0;
            r_cyc       <= '0;
            r_shown     <= mte_pkg::CH_SPACE;
            r_timer     <= 1'b0;
            r_tick      <= '0;
            r_idx       <= '0;
            r_last_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            r_cursor    <= n_cursor;
            r_pend      <= n_pend;
            r_pkey      <= n_pkey;
            r_cyc       <= n_cyc;
            r_shown     <= n_shown;
            r_timer     <= n_timer;
            r_tick      <= n_tick;
            r_idx       <= n_idx;
            r_last_idx  <= n_last_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_char  <= n_char;
        r_col   <= n_col;
        r_olast <= n_olast;
    end

    // name store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_shown;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_char_code = r_char;
    assign o_column    = r_col;
    assign o_last      = r_olast;

`ifndef SYNTHESIS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CW'(NAME_LEN))
        else $error("cursor beyond name length");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld_char || i_cmd.accept) |-> o_status.out_free)
        else $error("output register overwritten while held");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_char |-> (r_idx <= r_last_idx))
        else $error("readout index past end of name");

    a_pend_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (3'(r_cyc) < mte_pkg::key_count(r_pkey)))
        else $error("pending letter with bad key or cycle index");
`endif

endmodule

// ----- src/multitap_text_entry_unit.sv -----
// channel   direction  handshake                 payload
// ------    ---------  ------------------------  ------------------------------------
// input     in         i_valid / o_stall         i_func, i_key_digit, i_column_in
// result    out        o_valid / i_stall         o_kind, o_char_code, o_column, o_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (timeout ticks)
//
// a key, tick, delete, new name or set column event is taken directly from idle, and its
// result (if any) sits in the output register the next cycle
// finish streams the name one character at a time (name store read register, then
// output register); the next character is read only after the last one is loaded
// reset is synchronous, active low; the name store has no reset and no clearing pass
// input is stalled while the output register holds an untaken result or a readout runs
module multitap_text_entry_unit #(
    parameter int NAME_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event transactions
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_key_digit,
    input  logic [4:0]  i_column_in,
    // result transactions
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [6:0]  o_char_code,
    output logic [4:0]  o_column,
    output logic        o_last,
    // timeout register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    mte_pkg::t_cmd    cmd;
    mte_pkg::t_status status;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: idle, then read / load per name character during readout
    mte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // entry state, name store, tick timer and output register
    mte_dp #(
        .NAME_LEN (NAME_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_func      (i_func),
        .i_key_digit (i_key_digit),
        .i_column_in (i_column_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_char_code (o_char_code),
        .o_column    (o_column),
        .o_last      (o_last)
    );

endmodule
